@@ rtl/u2m_pkg.sv @@
package u2m_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_BYTES   = 8;
    localparam int SX_MAX_PAY  = 6;

    typedef enum logic [2:0] {
        EV_OK             = 3'd0,
        EV_MALFORMED      = 3'd1,
        EV_SX_INTERRUPTED = 3'd2,
        EV_SX_OUT_OF_SEQ  = 3'd3,
        EV_UTILITY        = 3'd4,
        EV_UNSUPPORTED    = 3'd5,
        EV_FOREIGN        = 3'd6
    } event_t;

    localparam logic [3:0] MT_UTILITY = 4'h0;
    localparam logic [3:0] MT_SYSTEM  = 4'h1;
    localparam logic [3:0] MT_CV1     = 4'h2;
    localparam logic [3:0] MT_SYSEX7  = 4'h3;
    localparam logic [3:0] MT_STREAM  = 4'hF;

    localparam logic [3:0] SX_COMPLETE = 4'h0;
    localparam logic [3:0] SX_START    = 4'h1;
    localparam logic [3:0] SX_CONTINUE = 4'h2;
    localparam logic [3:0] SX_END      = 4'h3;

    localparam logic [7:0] ST_SX_BEGIN = 8'hF0;
    localparam logic [7:0] ST_SX_EOX   = 8'hF7;
    localparam logic [7:0] ST_MTC      = 8'hF1;
    localparam logic [7:0] ST_SPP      = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] ST_TUNE     = 8'hF6;
    localparam logic [7:0] ST_RT_BASE  = 8'hF8;

    localparam logic [3:0] CV_LOW      = 4'h8;
    localparam logic [3:0] CV_PROG     = 4'hC;
    localparam logic [3:0] CV_CH_PRESS = 4'hD;
    localparam logic [3:0] CV_SYSTEM   = 4'hF;

    // One finished packet: up to eight wire bytes plus its event code.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0]      data;
        logic [$clog2(MAX_BYTES+1)-1:0] count;
        event_t                         event_code;
    } pkt_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [2:0] pkt_len(input logic [3:0] mt);
        logic [2:0] len;
        unique case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: len = 3'd1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: len = 3'd2;
            4'hB, 4'hC:                   len = 3'd3;
            default:                      len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/u2m_front.sv @@
module u2m_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            group_select_wr_en,
    input  logic [3:0]      group_select,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [31:0]     ump_word,
    input  u2m_pkg::q_stat_t q_stat,
    output logic            push,
    output u2m_pkg::pkt_t   pkt
);
    import u2m_pkg::*;

    logic [3:0]  group_reg;
    logic [1:0]  words_left_reg, words_left_next;
    logic        sysex_open_reg, sysex_open_next;
    logic [31:0] held_reg;
    logic        accept;
    logic        finish;
    logic [31:0] w0, w1;
    logic        sx_next;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        logic [2:0] len;
        len             = pkt_len(ump_word[31:28]);
        words_left_next = words_left_reg;
        finish          = 1'b0;
        w0              = ump_word;
        w1              = '0;
        if (accept)
        begin
            if (words_left_reg == 2'd0)
            begin
                if (len > 3'd1)
                    words_left_next = 2'(len - 3'd1);
                else
                    finish = 1'b1;
            end
            else
            begin
                words_left_next = words_left_reg - 2'd1;
                if (words_left_reg == 2'd1)
                begin
                    finish = 1'b1;
                    w0     = held_reg;
                    w1     = ump_word;
                end
            end
        end
    end

    // Packet decode
    always_comb
    begin
        logic [3:0] mt;
        logic [7:0] st, b1, b2;
        logic [3:0] sn, nb;
        logic [1:0] nd;
        logic       bad_nd;
        logic       two;
        logic       bad7;
        logic       start, stop, emit;
        logic [7:0] pay [SX_MAX_PAY];
        mt      = w0[31:28];
        st      = w0[23:16];
        b1      = w0[15:8];
        b2      = w0[7:0];
        sn      = w0[23:20];
        nb      = w0[19:16];
        nd      = 2'd0;
        bad_nd  = 1'b0;
        two     = 1'b0;
        bad7    = 1'b0;
        start   = 1'b0;
        stop    = 1'b0;
        emit    = 1'b0;
        pay[0]  = w0[15:8];
        pay[1]  = w0[7:0];
        pay[2]  = w1[31:24];
        pay[3]  = w1[23:16];
        pay[4]  = w1[15:8];
        pay[5]  = w1[7:0];
        pkt     = '0;
        pkt.event_code = EV_OK;
        sx_next = sysex_open_reg;
        if (mt != MT_UTILITY && mt != MT_STREAM && w0[27:24] != group_reg)
        begin
            pkt.event_code = EV_FOREIGN;
        end
        else if (mt == MT_UTILITY)
        begin
            pkt.event_code = EV_UTILITY;
        end
        else if (mt == MT_SYSTEM)
        begin
            if (st >= ST_RT_BASE)
            begin
                pkt.data[0] = st;
                pkt.count   = 4'd1;
            end
            else
            begin
                priority if (st == ST_MTC || st == ST_SONG_SEL)
                    nd = 2'd1;
                else if (st == ST_SPP)
                    nd = 2'd2;
                else if (st == ST_TUNE)
                    nd = 2'd0;
                else
                    bad_nd = 1'b1;
                if (bad_nd || (nd >= 2'd1 && b1[7]) || (nd >= 2'd2 && b2[7]))
                begin
                    pkt.event_code = EV_MALFORMED;
                end
                else
                begin
                    pkt.data[0] = st;
                    pkt.data[1] = b1;
                    pkt.data[2] = b2;
                    pkt.count   = 4'd1 + {2'b00, nd};
                end
            end
        end
        else if (mt == MT_CV1)
        begin
            two = !(sn == CV_PROG || sn == CV_CH_PRESS);
            if (sn < CV_LOW || sn == CV_SYSTEM || b1[7] || (two && b2[7]))
            begin
                pkt.event_code = EV_MALFORMED;
            end
            else
            begin
                pkt.data[0] = {sn, w0[19:16]};
                pkt.data[1] = b1;
                pkt.data[2] = b2;
                pkt.count   = two ? 4'd3 : 4'd2;
            end
        end
        else if (mt == MT_SYSEX7)
        begin
            for (int i = 0; i < SX_MAX_PAY; i++)
                if (4'(i) < nb && pay[i][7])
                    bad7 = 1'b1;
            if (nb > 4'(SX_MAX_PAY) || bad7)
            begin
                pkt.event_code = EV_MALFORMED;
            end
            else if (sn == SX_COMPLETE || sn == SX_START)
            begin
                if (sysex_open_reg)
                    pkt.event_code = EV_SX_INTERRUPTED;
                start = 1'b1;
                emit  = 1'b1;
            end
            else if (sn == SX_CONTINUE || sn == SX_END)
            begin
                if (!sysex_open_reg)
                    pkt.event_code = EV_SX_OUT_OF_SEQ;
                else
                    emit = 1'b1;
            end
            else
            begin
                pkt.event_code = EV_MALFORMED;
            end
            if (emit)
            begin
                stop = (sn == SX_COMPLETE || sn == SX_END);
                pkt.data[0] = ST_SX_BEGIN;
                for (int i = 0; i < SX_MAX_PAY; i++)
                    pkt.data[3'(i) + {2'b00, start}] = pay[i];
                if (stop)
                    pkt.data[nb[2:0] + {2'b00, start}] = ST_SX_EOX;
                pkt.count = nb + {3'b000, start} + {3'b000, stop};
                sx_next   = !stop;
            end
        end
        else
        begin
            pkt.event_code = EV_UNSUPPORTED;
        end
    end

    assign push            = finish;
    assign sysex_open_next = finish ? sx_next : sysex_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg      <= '0;
            words_left_reg <= '0;
            sysex_open_reg <= 1'b0;
        end
        else
        begin
            if (group_select_wr_en)
                group_reg <= group_select;
            words_left_reg <= words_left_next;
            sysex_open_reg <= sysex_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && words_left_reg == 2'd0)
            held_reg <= ump_word;
    end

endmodule

@@ rtl/u2m_queue.sv @@
module u2m_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  u2m_pkg::q_ctrl_t ctrl,
    input  u2m_pkg::pkt_t    wr_pkt,
    output u2m_pkg::pkt_t    rd_pkt,
    output u2m_pkg::q_stat_t stat
);
    import u2m_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    pkt_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_pkt     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (ctrl.push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (ctrl.pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (ctrl.push && !ctrl.pop)
            cnt_next = cnt_reg + 1'b1;
        else if (ctrl.pop && !ctrl.push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem_reg[wr_ptr_reg] <= wr_pkt;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && stat.full && !ctrl.pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.pop && stat.empty))
        else $error("queue pop while empty");

endmodule

@@ rtl/u2m_back.sv @@
module u2m_back (
    input  logic            clk,
    input  logic            rst_n,
    input  u2m_pkg::pkt_t   head,
    input  u2m_pkg::q_stat_t q_stat,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic [2:0]      event_code,
    output logic            last
);
    import u2m_pkg::*;

    localparam int KW = $clog2(MAX_BYTES);

    logic [KW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          byte_valid_reg, byte_valid_next;
    logic [2:0]    event_code_reg, event_code_next;
    logic          last_reg, last_next;
    logic          load;
    logic          cur_last;
    logic          has_bytes;

    assign has_bytes = (head.count != '0);
    assign cur_last  = !has_bytes || (($bits(head.count))'(k_reg) + 1'b1 == head.count);
    assign load      = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign pop       = load && cur_last;

    always_comb
    begin
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        event_code_next = event_code_reg;
        last_next       = last_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = has_bytes ? head.data[k_reg] : 8'h00;
            byte_valid_next = has_bytes;
            event_code_next = head.event_code;
            last_next       = cur_last;
            k_next          = cur_last ? '0 : k_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            event_code_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            event_code_reg <= event_code_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign event_code = event_code_reg;
    assign last       = last_reg;

    a_event_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && out_byte == 8'h00)
        else $error("event-only result not final");

    a_mid_packet_head: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg != '0 |-> !q_stat.empty)
        else $error("byte index nonzero with empty queue");

endmodule

@@ rtl/ump_to_midi1_byte_stream.sv @@
// UMP words in, MIDI 1.0 wire bytes out.
// Throughput: one word per cycle in while in_stall is low; one result transfer per cycle out while out_stall is low.
// A packet of n bytes takes n result transfers on the output side (one for event-only).
// The final word's transfer writes the packet into the queue; the back end then registers its first result.
// A two-entry packet queue decouples the word side; in_stall is high while it is full.
// Reset: async active low; clears group_select, word count, SysEx state, queue.
module ump_to_midi1_byte_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        group_select_wr_en,
    input  logic [3:0]  group_select,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] ump_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic [2:0]  event_code,
    output logic        last
);
    import u2m_pkg::*;

    pkt_t    wr_pkt;
    pkt_t    rd_pkt;
    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    u2m_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .group_select_wr_en (group_select_wr_en),
        .group_select       (group_select),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .ump_word           (ump_word),
        .q_stat             (q_stat),
        .push               (push),
        .pkt                (wr_pkt)
    );

    u2m_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_pkt (wr_pkt),
        .rd_pkt (rd_pkt),
        .stat   (q_stat)
    );

    u2m_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (rd_pkt),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .event_code (event_code),
        .last       (last)
    );

endmodule

@@ dv/ump_checker.sv @@
`timescale 1ns / 1ps
module ump_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        group_select_wr_en,
    input  logic [3:0]  group_select,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] ump_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic [2:0]  event_code,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import u2m_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       carries;
        event_t     code;
        logic       is_last;
    } wire_result_t;

    wire_result_t midi_out_q[$];

    logic [3:0]  active_group;
    logic        sysex_open;
    logic [1:0]  words_left;
    logic [31:0] held_word;

    function automatic int ump_words(input logic [3:0] mt);
        case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: return 1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: return 2;
            4'hB, 4'hC:                   return 3;
            default:                      return 4;
        endcase
    endfunction

    // Turns one complete packet into the wire bytes and event it must produce.
    task automatic translate_packet(input logic [31:0] w0, input logic [31:0] w1);
        logic [7:0]   bytes_out [8];
        logic [7:0]   pay [6];
        logic [7:0]   st;
        logic [7:0]   d1;
        logic [7:0]   d2;
        logic [3:0]   mt;
        logic [3:0]   sn;
        logic [3:0]   nb;
        event_t       ev;
        wire_result_t r;
        int           n;
        int           nd;
        int           i;
        bit           bad;
        bit           two;
        n  = 0;
        ev = EV_OK;
        mt = w0[31:28];
        st = w0[23:16];
        sn = w0[23:20];
        nb = w0[19:16];
        d1 = w0[15:8];
        d2 = w0[7:0];
        if (mt != MT_UTILITY && mt != MT_STREAM && w0[27:24] != active_group)
            ev = EV_FOREIGN;
        else if (mt == MT_UTILITY)
            ev = EV_UTILITY;
        else if (mt == MT_SYSTEM)
        begin
            if (st >= ST_RT_BASE)
            begin
                bytes_out[0] = st;
                n = 1;
            end
            else
            begin
                case (st)
                    ST_MTC, ST_SONG_SEL: nd = 1;
                    ST_SPP:              nd = 2;
                    ST_TUNE:             nd = 0;
                    default:             nd = -1;
                endcase
                if (nd < 0 || (nd >= 1 && d1[7]) || (nd >= 2 && d2[7]))
                    ev = EV_MALFORMED;
                else
                begin
                    bytes_out[0] = st;
                    bytes_out[1] = d1;
                    bytes_out[2] = d2;
                    n = nd + 1;
                end
            end
        end
        else if (mt == MT_CV1)
        begin
            two = (sn != CV_PROG) && (sn != CV_CH_PRESS);
            if (sn < CV_LOW || sn == CV_SYSTEM || d1[7] || (two && d2[7]))
                ev = EV_MALFORMED;
            else
            begin
                bytes_out[0] = {sn, w0[19:16]};
                bytes_out[1] = d1;
                bytes_out[2] = d2;
                n = two ? 3 : 2;
            end
        end
        else if (mt == MT_SYSEX7)
        begin
            pay[0] = w0[15:8];
            pay[1] = w0[7:0];
            pay[2] = w1[31:24];
            pay[3] = w1[23:16];
            pay[4] = w1[15:8];
            pay[5] = w1[7:0];
            bad = (nb > SX_MAX_PAY);
            for (i = 0; i < SX_MAX_PAY; i++)
                if (i < nb && pay[i][7])
                    bad = 1'b1;
            if (bad)
                ev = EV_MALFORMED;
            else if (sn == SX_COMPLETE || sn == SX_START)
            begin
                if (sysex_open)
                    ev = EV_SX_INTERRUPTED;
                bytes_out[0] = ST_SX_BEGIN;
                n = 1;
            end
            else if (sn == SX_CONTINUE || sn == SX_END)
            begin
                if (!sysex_open)
                    ev = EV_SX_OUT_OF_SEQ;
            end
            else
                ev = EV_MALFORMED;
            if (ev == EV_OK || ev == EV_SX_INTERRUPTED)
            begin
                for (i = 0; i < nb; i++)
                begin
                    bytes_out[n] = pay[i];
                    n = n + 1;
                end
                if (sn == SX_COMPLETE || sn == SX_END)
                begin
                    bytes_out[n] = ST_SX_EOX;
                    n = n + 1;
                    sysex_open = 1'b0;
                end
                else
                    sysex_open = 1'b1;
            end
        end
        else
            ev = EV_UNSUPPORTED;

        if (n == 0)
        begin
            r = '{data: 8'h00, carries: 1'b0, code: ev, is_last: 1'b1};
            midi_out_q.push_back(r);
        end
        for (i = 0; i < n; i++)
        begin
            r = '{data: bytes_out[i], carries: 1'b1, code: ev, is_last: (i == n - 1)};
            midi_out_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wire_result_t want;
        int           len;
        if (!rst_n)
        begin
            midi_out_q.delete();
            active_group = 4'h0;
            sysex_open   = 1'b0;
            words_left   = 2'd0;
            held_word    = 32'h0;
            fail_count   = 0;
            results_seen = 0;
        end
        else
        begin
            if (group_select_wr_en)
                active_group = group_select;

            if (in_valid && !in_stall)
            begin
                if (words_left == 2'd0)
                begin
                    len = ump_words(ump_word[31:28]);
                    if (len > 1)
                    begin
                        held_word  = ump_word;
                        words_left = 2'(len - 1);
                    end
                    else
                        translate_packet(ump_word, 32'h0);
                end
                else
                begin
                    words_left = words_left - 2'd1;
                    if (words_left == 2'd0)
                        translate_packet(held_word, ump_word);
                end
            end

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (midi_out_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte=%h byte_valid=%b event_code=%0d last=%b",
                           out_byte, byte_valid, event_code, last);
                    fail_count++;
                end
                else
                begin
                    want = midi_out_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, out_byte);
                        fail_count++;
                    end
                    if (byte_valid !== want.carries)
                    begin
                        $error("byte_valid: expected %b, got %b", want.carries, byte_valid);
                        fail_count++;
                    end
                    if (event_code !== want.code)
                    begin
                        $error("event_code: expected %0d, got %0d", want.code, event_code);
                        fail_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %b, got %b", want.is_last, last);
                        fail_count++;
                    end
                end
            end
        end
        pending = midi_out_q.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import u2m_pkg::*;

    logic        clk                = 1'b0;
    logic        rst_n              = 1'b0;
    logic        group_select_wr_en = 1'b0;
    logic [3:0]  group_select       = 4'h0;
    logic        in_valid           = 1'b0;
    logic        in_stall;
    logic [31:0] ump_word           = 32'h0;
    logic        out_valid;
    logic        out_stall          = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [2:0]  event_code;
    logic        last;

    int fail_count;
    int pending;
    int results_seen;

    bit idle_on   = 1'b1;
    bit stall_on  = 1'b1;
    bit hold_long = 1'b0;
    int words_sent = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ump_to_midi1_byte_stream u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .group_select_wr_en (group_select_wr_en),
        .group_select       (group_select),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .ump_word           (ump_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_byte           (out_byte),
        .byte_valid         (byte_valid),
        .event_code         (event_code),
        .last               (last)
    );

    ump_checker u_chk (.*);

    function automatic int packet_words(input logic [3:0] mt);
        case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: return 1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: return 2;
            4'hB, 4'hC:                   return 3;
            default:                      return 4;
        endcase
    endfunction

    // One word transfer; an optional idle burst goes ahead of it.
    task automatic send_word(input logic [31:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ump_word <= w;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    task automatic send_packet(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3);
        int n;
        n = packet_words(w0[31:28]);
        send_word(w0);
        if (n > 1)
            send_word(w1);
        if (n > 2)
            send_word(w2);
        if (n > 3)
            send_word(w3);
    endtask

    task automatic send_sysex(input logic [3:0] grp, input logic [3:0] st,
                              input logic [3:0] nb);
        logic [31:0] r;
        r = $urandom() & 32'h7F7F_7F7F;
        send_packet({MT_SYSEX7, grp, st, nb, r[15:0]}, $urandom() & 32'h7F7F_7F7F, 0, 0);
    endtask

    task automatic send_sysex_message(input logic [3:0] grp);
        int parts;
        if ($urandom_range(0, 2) == 0)
            send_sysex(grp, SX_COMPLETE, 4'($urandom_range(0, SX_MAX_PAY)));
        else
        begin
            send_sysex(grp, SX_START, 4'($urandom_range(0, SX_MAX_PAY)));
            parts = $urandom_range(0, 2);
            repeat (parts)
                send_sysex(grp, SX_CONTINUE, 4'($urandom_range(0, SX_MAX_PAY)));
            send_sysex(grp, SX_END, 4'($urandom_range(0, SX_MAX_PAY)));
        end
    endtask

    task automatic send_random(input logic [3:0] grp);
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] r3;
        logic [7:0]  st;
        logic [3:0]  sn;
        r0 = $urandom();
        r1 = $urandom();
        r2 = $urandom();
        r3 = $urandom();
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                sn = 4'($urandom_range(CV_LOW, CV_SYSTEM - 1));
                send_packet({MT_CV1, grp, sn, r0[19:16], r0[15:0] & 16'h7F7F}, r1, r2, r3);
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       st = ST_MTC;
                    1:       st = ST_SPP;
                    2:       st = ST_SONG_SEL;
                    3:       st = ST_TUNE;
                    default: st = ST_RT_BASE | {5'd0, r0[18:16]};
                endcase
                send_packet({MT_SYSTEM, grp, st,
                             (st >= ST_RT_BASE) ? r0[15:0] : (r0[15:0] & 16'h7F7F)},
                            r1, r2, r3);
            end
            4, 5, 6: send_sysex_message(grp);
            7:       send_packet({MT_UTILITY, r0[27:0]}, r1, r2, r3);
            8:       send_packet(r0, r1, r2, r3);
            9:       send_packet({r0[31:28], grp, r0[23:0]}, r1, r2, r3);
            10:      send_packet({r0[31] ? MT_SYSTEM : MT_CV1, grp, r0[23:0]}, r1, r2, r3);
            default: send_packet({MT_SYSEX7, grp, r0[23:0]}, r1, r2, r3);
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_group(input logic [3:0] g);
        group_select_wr_en <= 1'b1;
        group_select       <= g;
        @(posedge clk);
        group_select_wr_en <= 1'b0;
    endtask

    task automatic run_random(input logic [3:0] grp, input int count);
        int start;
        start = words_sent;
        while (words_sent - start < count)
            send_random(grp);
    endtask

    // Output side: short random stalls, or one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (40) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("** ump_to_midi1_byte_stream: FAILED **");
        $finish;
    end

    initial
    begin
        logic [3:0] mid_group;
        mid_group = 4'($urandom_range(1, 14));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // group 0 after reset
        send_packet(32'h0000_0000, 0, 0, 0);
        send_packet(32'h10F8_0000, 0, 0, 0);
        send_packet(32'h10F1_7F00, 0, 0, 0);
        send_packet(32'h10F2_7F7F, 0, 0, 0);
        send_packet(32'h10F6_FFFF, 0, 0, 0);
        send_packet(32'h10F4_0000, 0, 0, 0);
        send_packet(32'h2090_3C7F, 0, 0, 0);
        send_packet(32'h20C5_0580, 0, 0, 0);
        send_packet(32'h20F0_0000, 0, 0, 0);
        send_packet(32'h2080_8000, 0, 0, 0);
        send_packet(32'h2190_3C7F, 0, 0, 0);
        send_packet(32'h3006_0102, 32'h0304_0506, 0, 0);
        send_packet(32'h3007_0000, 32'h0000_0000, 0, 0);
        send_packet(32'h3020_0000, 32'h0000_0000, 0, 0);
        send_packet(32'h3012_1122, 32'h0000_0000, 0, 0);
        send_packet(32'h3011_3300, 32'h0000_0000, 0, 0);
        send_packet(32'h3030_0000, 32'h0000_0000, 0, 0);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        write_group(4'hF);
        hold_long = 1'b1;
        repeat (12)
            send_packet({MT_CV1, 4'hF, CV_LOW, 4'h3, 16'h407F}, 0, 0, 0);
        run_random(4'hF, 45);
        drain();

        write_group(mid_group);
        run_random(mid_group, 45);
        drain();

        write_group(4'h0);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_random(4'h0, 45);
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d UMP words (directed cases, then random traffic under groups 15, %0d, 0)",
                 words_sent, mid_group);
        $display("and checked %0d byte-side transfers, including a long output hold-off.",
                 results_seen);
        if (fail_count == 0)
            $display("** ump_to_midi1_byte_stream: PASSED **");
        else
            $display("** ump_to_midi1_byte_stream: FAILED **");
        $finish;
    end

endmodule
